/* hdl/hag_pkg.sv */
`default_nettype none

package hag_pkg;

    // Field widths
    localparam int XY_W       = 32;
    localparam int DIST_W     = 62;
    localparam int HAG_W      = 33;
    localparam int CNT_W      = 7;
    localparam int RULE_W     = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 62;

    // Fixed-point weighting: weight = floor(2^WEIGHT_SHIFT / d2)
    localparam int WEIGHT_SHIFT = 40;
    localparam int WGT_W        = WEIGHT_SHIFT + 1;
    localparam int WSUM_W       = 64;
    // Sum of weight * z stays within +/- 2^(WSUM_W + XY_W - 1)
    localparam int ACC_W        = WSUM_W + XY_W + 1;
    localparam int DVD_W        = ACC_W - 1;
    localparam int DCNT_W       = $clog2(DVD_W + 1);
    localparam int PROD_W       = XY_W + 33;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEIGHBOUR_COUNT     = 3'd0,
        CFG_MAX_DIST_SQ         = 3'd1,
        CFG_ALLOW_EXTRAPOLATION = 3'd2,
        CFG_BOUND_MIN_X         = 3'd3,
        CFG_BOUND_MAX_X         = 3'd4,
        CFG_BOUND_MIN_Y         = 3'd5,
        CFG_BOUND_MAX_Y         = 3'd6
    } t_cfg_idx;

    // Which rule chose the ground height
    typedef enum logic [RULE_W-1:0] {
        RULE_NEAREST  = 2'd0,
        RULE_OUTSIDE  = 2'd1,
        RULE_WEIGHTED = 2'd2,
        RULE_NONE     = 2'd3
    } t_rule;

endpackage

`default_nettype wire

/* hdl/hag_in_if.sv */
`default_nettype none

interface hag_in_if import hag_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [XY_W-1:0]   query_x;
    logic signed [XY_W-1:0]   query_y;
    logic signed [XY_W-1:0]   query_z;
    logic signed [XY_W-1:0]   neighbour_z;
    logic        [DIST_W-1:0] neighbour_dist_sq;
    logic                     last_neighbour;

    modport source (
        output valid, query_x, query_y, query_z, neighbour_z, neighbour_dist_sq,
               last_neighbour,
        input  ready
    );
    modport sink (
        input  valid, query_x, query_y, query_z, neighbour_z, neighbour_dist_sq,
               last_neighbour,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/hag_out_if.sv */
`default_nettype none

interface hag_out_if import hag_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [HAG_W-1:0]  height_above_ground;
    logic        [RULE_W-1:0] rule_used;

    modport source (
        output valid, height_above_ground, rule_used,
        input  ready
    );
    modport sink (
        input  valid, height_above_ground, rule_used,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/height_above_ground_idw.sv */
// Height above ground by inverse-square-distance weighting.
// i_req carries one ground neighbour per request, nearest first, each with
// the query point; the request with last_neighbour set closes the query and
// yields one result on o_res: query_z minus the chosen ground height, and
// the rule that chose it. Configuration must be written through i_cfg_wr_en,
// i_cfg_index and i_cfg_data only while the block is idle; the block itself does not enforce this.
// Each neighbour runs a 41-step restoring division (2^40 / d2) on the shared
// divider, then an overflow check and a two-part multiply-accumulate; a neighbour
// beyond the distance limit, or any after it in the query, skips all of these.
// The last neighbour then passes the rule choice and, for the weighted mean, a
// 96-step division of the 97-bit sum by the weight sum, then rounding.
// i_req.ready is high only between requests. The result sits in an output
// register; while o_res is stalled the block keeps taking neighbours and
// waits only when the next result is due.
// Synchronous reset loads the register defaults and empties the run and
// the output register.
`default_nettype none

module height_above_ground_idw import hag_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hag_in_if.sink                i_req,
    hag_out_if.source             o_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WDIV,
        S_WCHK,
        S_MUL_LO,
        S_ADD_LO,
        S_ADD_HI,
        S_DECIDE,
        S_MDIV,
        S_MRND,
        S_PUSH
    } t_state;

    t_state r_state;

    // Configuration
    logic        [CNT_W-1:0]  r_ncnt;
    logic        [DIST_W-1:0] r_max_d2;
    logic                     r_allow_ext;
    logic signed [XY_W-1:0]   r_min_x, r_max_x, r_min_y, r_max_y;

    // Run state
    logic        [WSUM_W-1:0] r_wsum;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [XY_W-1:0]   r_nearest;
    logic                     r_exact;
    logic                     r_limit;
    logic                     r_first;

    // Current request
    logic signed [XY_W-1:0]   r_qx, r_qy, r_qz, r_nz;
    logic                     r_last;

    // Shared divider
    logic [DVD_W-1:0]         r_dvd;
    logic [WSUM_W-1:0]        r_rem;
    logic [WSUM_W-1:0]        r_dvsr;
    logic [WGT_W-1:0]         r_quot;
    logic [DCNT_W-1:0]        r_cnt;
    logic                     r_neg;

    // Multiplier output
    logic signed [PROD_W-1:0] r_prod;

    // Result waiting for the output register, and the output register
    logic signed [HAG_W-1:0]  r_res_hag;
    t_rule                    r_res_rule;
    logic                     r_out_valid;
    logic signed [HAG_W-1:0]  r_out_hag;
    t_rule                    r_out_rule;

    logic                     req_fire;
    logic                     limit_now;
    logic [WSUM_W+1:0]        div_sub;
    logic [WSUM_W:0]          rem_sh;
    logic                     div_ge;
    logic [WSUM_W:0]          wsum_add;
    logic signed [32:0]       mul_a;
    logic signed [PROD_W-1:0] prod;
    logic                     outside;
    logic signed [ACC_W-1:0]  acc_mag;
    logic                     rnd_up;
    logic [WGT_W-1:0]         q_rnd;
    logic signed [HAG_W-1:0]  mean_gnd;
    logic signed [HAG_W-1:0]  qz_ext;
    logic                     out_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    // Limit check on the incoming neighbour
    assign limit_now = r_limit ||
        ((r_max_d2 != '0) && (i_req.neighbour_dist_sq > r_max_d2));

    // One restoring division step
    assign rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign div_sub = {1'b0, rem_sh} - {2'b00, r_dvsr};
    assign div_ge  = !div_sub[WSUM_W+1];

    // Weight sum with carry out
    assign wsum_add = {1'b0, r_wsum} + {{(WSUM_W+1-WGT_W){1'b0}}, r_quot};

    // Weight times z on one multiplier: low part, then high part
    assign mul_a = (r_state == S_MUL_LO) ? $signed({1'b0, r_quot[31:0]})
                 : $signed({{(33-(WGT_W-32)){1'b0}}, r_quot[WGT_W-1:32]});
    assign prod  = mul_a * r_nz;

    // Ground bounds test, inclusive
    assign outside = !((r_qx >= r_min_x) && (r_qx <= r_max_x) &&
                       (r_qy >= r_min_y) && (r_qy <= r_max_y));

    assign acc_mag = r_acc[ACC_W-1] ? -r_acc : r_acc;

    // Round the mean to nearest, ties away from zero
    assign rnd_up   = ({r_rem, 1'b0} >= {1'b0, r_dvsr});
    assign q_rnd    = r_quot + {{(WGT_W-1){1'b0}}, rnd_up};
    assign mean_gnd = r_neg ? -$signed(q_rnd[HAG_W-1:0]) : $signed(q_rnd[HAG_W-1:0]);
    assign qz_ext   = HAG_W'(r_qz);

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ncnt      <= CNT_W'(1);
            r_max_d2    <= '0;
            r_allow_ext <= 1'b1;
            r_min_x     <= '0;
            r_max_x     <= '0;
            r_min_y     <= '0;
            r_max_y     <= '0;
            r_wsum      <= '0;
            r_acc       <= '0;
            r_nearest   <= '0;
            r_exact     <= 1'b0;
            r_limit     <= 1'b0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_NEIGHBOUR_COUNT:     r_ncnt      <= i_cfg_data[CNT_W-1:0];
                    CFG_MAX_DIST_SQ:         r_max_d2    <= i_cfg_data[DIST_W-1:0];
                    CFG_ALLOW_EXTRAPOLATION: r_allow_ext <= i_cfg_data[0];
                    CFG_BOUND_MIN_X:         r_min_x     <= i_cfg_data[XY_W-1:0];
                    CFG_BOUND_MAX_X:         r_max_x     <= i_cfg_data[XY_W-1:0];
                    CFG_BOUND_MIN_Y:         r_min_y     <= i_cfg_data[XY_W-1:0];
                    CFG_BOUND_MAX_Y:         r_max_y     <= i_cfg_data[XY_W-1:0];
                    default: ;
                endcase
            end

            // Drop the output once taken, unless a push refills it
            if (r_out_valid && o_res.ready && (r_state != S_PUSH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_qx    <= i_req.query_x;
                        r_qy    <= i_req.query_y;
                        r_qz    <= i_req.query_z;
                        r_nz    <= i_req.neighbour_z;
                        r_last  <= i_req.last_neighbour;
                        r_limit <= limit_now;
                        if (r_first) begin
                            r_nearest <= i_req.neighbour_z;
                            r_exact   <= (i_req.neighbour_dist_sq == '0);
                            r_first   <= 1'b0;
                        end
                        // Start 2^WEIGHT_SHIFT / d2, d2 of zero taken as one
                        r_dvd  <= {1'b1, {(DVD_W-1){1'b0}}};
                        r_rem  <= '0;
                        r_quot <= '0;
                        r_cnt  <= DCNT_W'(WGT_W);
                        if (i_req.neighbour_dist_sq == '0) begin
                            r_dvsr <= WSUM_W'(1);
                        end else begin
                            r_dvsr <= WSUM_W'(i_req.neighbour_dist_sq);
                        end
                        if (!limit_now) begin
                            r_state <= S_WDIV;
                        end else if (i_req.last_neighbour) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end

                S_WDIV, S_MDIV: begin
                    r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_rem  <= div_ge ? div_sub[WSUM_W-1:0] : rem_sh[WSUM_W-1:0];
                    r_quot <= {r_quot[WGT_W-2:0], div_ge};
                    r_cnt  <= r_cnt - DCNT_W'(1);
                    if (r_cnt == DCNT_W'(1)) begin
                        r_state <= (r_state == S_WDIV) ? S_WCHK : S_MRND;
                    end
                end

                // Skip a neighbour whose weight would overflow the sum
                S_WCHK: begin
                    if (!wsum_add[WSUM_W]) begin
                        r_wsum  <= wsum_add[WSUM_W-1:0];
                        r_state <= S_MUL_LO;
                    end else begin
                        r_state <= r_last ? S_DECIDE : S_IDLE;
                    end
                end

                S_MUL_LO: begin
                    r_prod  <= prod;
                    r_state <= S_ADD_LO;
                end

                S_ADD_LO: begin
                    r_acc   <= r_acc + ACC_W'(r_prod);
                    r_prod  <= prod;
                    r_state <= S_ADD_HI;
                end

                S_ADD_HI: begin
                    r_acc   <= r_acc + (ACC_W'(r_prod) <<< 32);
                    r_state <= r_last ? S_DECIDE : S_IDLE;
                end

                // Choose the rule, load the mean division, clear the run
                S_DECIDE: begin
                    if (r_exact || (r_ncnt <= CNT_W'(1))) begin
                        r_res_hag  <= qz_ext - HAG_W'(r_nearest);
                        r_res_rule <= RULE_NEAREST;
                        r_state    <= S_PUSH;
                    end else if (outside && !r_allow_ext) begin
                        r_res_hag  <= '0;
                        r_res_rule <= RULE_OUTSIDE;
                        r_state    <= S_PUSH;
                    end else if (r_wsum == '0) begin
                        r_res_hag  <= '0;
                        r_res_rule <= RULE_NONE;
                        r_state    <= S_PUSH;
                    end else begin
                        r_res_rule <= RULE_WEIGHTED;
                        r_neg      <= r_acc[ACC_W-1];
                        r_dvd      <= acc_mag[DVD_W-1:0];
                        r_dvsr     <= r_wsum;
                        r_rem      <= '0;
                        r_quot     <= '0;
                        r_cnt      <= DCNT_W'(DVD_W);
                        r_state    <= S_MDIV;
                    end
                    r_wsum    <= '0;
                    r_acc     <= '0;
                    r_nearest <= '0;
                    r_exact   <= 1'b0;
                    r_limit   <= 1'b0;
                    r_first   <= 1'b1;
                end

                S_MRND: begin
                    r_res_hag <= qz_ext - mean_gnd;
                    r_state   <= S_PUSH;
                end

                // Hold until the output register is free
                S_PUSH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hag   <= r_res_hag;
                        r_out_rule  <= r_res_rule;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid               = r_out_valid;
    assign o_res.height_above_ground = r_out_hag;
    assign o_res.rule_used           = r_out_rule;

    // Rules that fall back to the query's own z report zero height
    a_fallback_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.rule_used == RULE_OUTSIDE || o_res.rule_used == RULE_NONE)
        |-> o_res.height_above_ground == '0)
        else $error("fallback rule with nonzero height");

    // Weight never exceeds 2^WEIGHT_SHIFT
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WCHK |-> r_quot <= (WGT_W'(1) << WEIGHT_SHIFT))
        else $error("weight out of range");

    // Divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WDIV || r_state == S_MDIV) |-> (r_rem < r_dvsr) && (r_cnt != '0))
        else $error("divider remainder out of range");

    // A nonzero weighted sum implies a nonzero weight sum
    a_sum_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc != '0 |-> r_wsum != '0)
        else $error("weighted sum without weight");

endmodule

`default_nettype wire
